### sv/pcs_pkg.sv
// types, codes and reset constants shared by the precharge contactor sequencer
package pcs_pkg;

    // field widths of the transactions and registers
    localparam int unsigned PACK_W   = 14;
    localparam int unsigned SENSOR_W = 12;
    localparam int unsigned GAIN_W   = 16;
    localparam int unsigned OFFSET_W = 12;
    localparam int unsigned TICK_W   = 8;
    localparam int unsigned THRESH_W = 17;
    localparam int unsigned PROD_W   = PACK_W + GAIN_W;
    localparam int unsigned PHASE_W  = 3;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_GAIN      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_OFFSET_MV = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUALIFY_TICKS       = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_DELAY_TICKS   = 8'd3;

    // configuration reset values
    localparam logic [GAIN_W-1:0]   GAIN_RESET        = 16'd4648;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET      = 12'd328;
    localparam logic [TICK_W-1:0]   QUALIFY_RESET     = 8'd5;
    localparam logic [TICK_W-1:0]   CLOSE_DELAY_RESET = 8'd3;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    // sequencer phase
    typedef enum logic [PHASE_W-1:0] {
        PH_WAIT  = 3'd0,
        PH_QUAL  = 3'd1,
        PH_DELAY = 3'd2,
        PH_DONE  = 3'd3,
        PH_FAULT = 3'd4
    } phase_t;

    // live configuration
    typedef struct packed {
        logic [GAIN_W-1:0]   threshold_gain;
        logic [OFFSET_W-1:0] threshold_offset_mv;
        logic [TICK_W-1:0]   qualify_ticks;
        logic [TICK_W-1:0]   close_delay_ticks;
    } cfg_t;

    // one result transaction
    typedef struct packed {
        logic               main_relay_en;
        logic               precharge_relay_en;
        logic               fault_latched;
        logic [PHASE_W-1:0] phase;
    } result_t;

endpackage

### sv/precharge_contactor_sequencer.sv
// precharge contactor sequencer top level: input register, core, result register
//
// Usage: each transaction on the s_ channel is one 10 ms tick carrying pack
// voltage, contactor sense, fault flag and current-sensor voltage. Every tick
// gives exactly one transaction on the m_ channel with the relay drives, the
// fault latch and the phase after that tick.
// Path: a tick accepted into the input register is processed as it moves on
// to the result register, and its result is offered on m_ from then on.
// Throughput: one tick per cycle while m_ready stays high, set by the single
// pass through the phase logic and the 14 x 16 threshold multiplier between
// the input register and the core state and result registers.
// Stall: while m_ready is low the result register holds; the input register
// still takes one more tick, then s_ready drops until the result is taken.
// Configuration: cfg_valid/cfg_index/cfg_data write registers 0..3 (gain,
// offset, qualify ticks, close delay); cfg_ready is always high, other
// indexes are ignored. Write only while no tick is in flight.
// Reset (aresetn low, synchronous): both registers empty, phase waiting,
// configuration at its defaults; the relay drive outputs are not reset.
module precharge_contactor_sequencer (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [pcs_pkg::PACK_W-1:0]       s_pack_voltage_dv,
    input  logic                             s_contactor_sense,
    input  logic                             s_fault_flag,
    input  logic [pcs_pkg::SENSOR_W-1:0]     s_sensor_mv,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_main_relay_en,
    output logic                             m_precharge_relay_en,
    output logic                             m_fault_latched,
    output logic [pcs_pkg::PHASE_W-1:0]      m_phase,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pcs_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic                             in_valid_reg;
    logic [pcs_pkg::PACK_W-1:0]       pack_reg;
    logic                             sense_reg;
    logic                             fault_reg;
    logic [pcs_pkg::SENSOR_W-1:0]     sensor_reg;

    logic                             out_valid_reg, out_valid_next;
    pcs_pkg::result_t                 out_reg;
    pcs_pkg::result_t                 result;
    pcs_pkg::cfg_t                    cfg;

    logic                             advance;
    logic                             s_take;

    // handshake: a held tick moves on when the result slot is free or draining
    assign advance        = in_valid_reg & (~out_valid_reg | m_ready);
    assign s_ready        = ~in_valid_reg | advance;
    assign s_take         = s_valid & s_ready;
    assign out_valid_next = advance | (out_valid_reg & ~m_ready);

    pcs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pcs_core u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step_en         (advance),
        .pack_voltage_dv (pack_reg),
        .contactor_sense (sense_reg),
        .fault_flag      (fault_reg),
        .sensor_mv       (sensor_reg),
        .cfg             (cfg),
        .result          (result)
    );

    // input register valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // input register payload
    always_ff @(posedge aclk) begin
        if (s_take) begin
            pack_reg   <= s_pack_voltage_dv;
            sense_reg  <= s_contactor_sense;
            fault_reg  <= s_fault_flag;
            sensor_reg <= s_sensor_mv;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_main_relay_en      = out_reg.main_relay_en;
    assign m_precharge_relay_en = out_reg.precharge_relay_en;
    assign m_fault_latched      = out_reg.fault_latched;
    assign m_phase              = out_reg.phase;

endmodule

### sv/pcs_cfg.sv
// configuration register bank of the sequencer
module pcs_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pcs_pkg::CFG_DATA_W-1:0]   cfg_data,
    output pcs_pkg::cfg_t                    cfg
);

    pcs_pkg::cfg_t cfg_reg;
    pcs_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg        = cfg_reg;

    // decode a write; unknown indexes leave the bank alone
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                pcs_pkg::REG_THRESHOLD_GAIN:
                    cfg_next.threshold_gain = cfg_data[pcs_pkg::GAIN_W-1:0];
                pcs_pkg::REG_THRESHOLD_OFFSET_MV:
                    cfg_next.threshold_offset_mv = cfg_data[pcs_pkg::OFFSET_W-1:0];
                pcs_pkg::REG_QUALIFY_TICKS:
                    cfg_next.qualify_ticks = cfg_data[pcs_pkg::TICK_W-1:0];
                pcs_pkg::REG_CLOSE_DELAY_TICKS:
                    cfg_next.close_delay_ticks = cfg_data[pcs_pkg::TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // register bank
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold_gain      <= pcs_pkg::GAIN_RESET;
            cfg_reg.threshold_offset_mv <= pcs_pkg::OFFSET_RESET;
            cfg_reg.qualify_ticks       <= pcs_pkg::QUALIFY_RESET;
            cfg_reg.close_delay_ticks   <= pcs_pkg::CLOSE_DELAY_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### sv/pcs_core.sv
// phase state machine, threshold latch and tick counters of the sequencer
module pcs_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             step_en,
    input  logic [pcs_pkg::PACK_W-1:0]       pack_voltage_dv,
    input  logic                             contactor_sense,
    input  logic                             fault_flag,
    input  logic [pcs_pkg::SENSOR_W-1:0]     sensor_mv,
    input  pcs_pkg::cfg_t                    cfg,
    output pcs_pkg::result_t                 result
);

    pcs_pkg::phase_t                   phase_reg, phase_next;
    logic [pcs_pkg::THRESH_W-1:0]      threshold_reg, threshold_next;
    logic [pcs_pkg::TICK_W-1:0]        below_reg, below_next;
    logic [pcs_pkg::TICK_W-1:0]        delay_reg, delay_next;

    logic                              tripped;
    logic [pcs_pkg::TICK_W-1:0]        need;
    logic [pcs_pkg::TICK_W-1:0]        below_inc;
    logic [pcs_pkg::TICK_W-1:0]        delay_inc;
    logic [pcs_pkg::PROD_W-1:0]        prod;
    logic [pcs_pkg::THRESH_W-1:0]      threshold_calc;

    // shared terms
    assign tripped   = fault_flag | ~contactor_sense;
    assign need      = (cfg.qualify_ticks == '0) ? pcs_pkg::TICK_W'(1) : cfg.qualify_ticks;
    assign below_inc = (below_reg == pcs_pkg::TICK_MAX) ? below_reg
                                                       : below_reg + pcs_pkg::TICK_W'(1);
    assign delay_inc = (delay_reg == pcs_pkg::TICK_MAX) ? delay_reg
                                                       : delay_reg + pcs_pkg::TICK_W'(1);

    // threshold: offset plus pack voltage times Q16 gain
    assign prod = pcs_pkg::PROD_W'(pack_voltage_dv) * pcs_pkg::PROD_W'(cfg.threshold_gain);
    assign threshold_calc = pcs_pkg::THRESH_W'(cfg.threshold_offset_mv)
                          + pcs_pkg::THRESH_W'(prod[pcs_pkg::PROD_W-1:16]);

    // next state
    always_comb begin
        phase_next     = phase_reg;
        threshold_next = threshold_reg;
        below_next     = below_reg;
        delay_next     = delay_reg;
        unique case (phase_reg)
            pcs_pkg::PH_WAIT: begin
                if (pack_voltage_dv != '0 && contactor_sense) begin
                    threshold_next = threshold_calc;
                    below_next     = '0;
                    phase_next     = pcs_pkg::PH_QUAL;
                end
            end
            pcs_pkg::PH_QUAL: begin
                if (tripped) begin
                    phase_next = pcs_pkg::PH_FAULT;
                end else begin
                    below_next = (pcs_pkg::THRESH_W'(sensor_mv) < threshold_reg) ? below_inc
                                                                                 : '0;
                    if (below_next >= need) begin
                        delay_next = '0;
                        phase_next = (cfg.close_delay_ticks == '0) ? pcs_pkg::PH_DONE
                                                                   : pcs_pkg::PH_DELAY;
                    end
                end
            end
            pcs_pkg::PH_DELAY: begin
                delay_next = delay_inc;
                if (delay_inc >= cfg.close_delay_ticks) begin
                    phase_next = pcs_pkg::PH_DONE;
                end
            end
            pcs_pkg::PH_DONE: begin
                if (tripped) begin
                    phase_next = pcs_pkg::PH_FAULT;
                end
            end
            default: begin
                phase_next = pcs_pkg::PH_FAULT;
            end
        endcase
    end

    // relay drives from the phase after this tick
    always_comb begin
        result.phase         = phase_next;
        result.fault_latched = 1'b0;
        unique case (phase_next)
            pcs_pkg::PH_WAIT, pcs_pkg::PH_QUAL: begin
                result.main_relay_en      = 1'b0;
                result.precharge_relay_en = 1'b1;
            end
            pcs_pkg::PH_DELAY: begin
                result.main_relay_en      = 1'b1;
                result.precharge_relay_en = 1'b1;
            end
            pcs_pkg::PH_DONE: begin
                result.main_relay_en      = 1'b1;
                result.precharge_relay_en = 1'b0;
            end
            default: begin
                result.main_relay_en      = 1'b0;
                result.precharge_relay_en = 1'b0;
                result.fault_latched      = 1'b1;
            end
        endcase
    end

    // state registers, advanced once per transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= pcs_pkg::PH_WAIT;
            threshold_reg <= '0;
            below_reg     <= '0;
            delay_reg     <= '0;
        end else if (step_en) begin
            phase_reg     <= phase_next;
            threshold_reg <= threshold_next;
            below_reg     <= below_next;
            delay_reg     <= delay_next;
        end
    end

endmodule

### tb/sv/precharge_contactor_sequencer_test.sv
// self-checking testbench for the precharge contactor sequencer, one pass from waiting to fault
module precharge_contactor_sequencer_test;
    timeunit 1ns;
    timeprecision 1ps;
    import pcs_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 100;
    localparam int LONG_HOLD      = 64;
    localparam int SENSOR_MAX     = (1 << SENSOR_W) - 1;
    localparam int PACK_MAX       = (1 << PACK_W) - 1;

    // indexes that decode to no register
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

    // one tick as driven on the s_ channel
    typedef struct packed {
        logic [PACK_W-1:0]   pack_dv;
        logic                sense;
        logic                fault;
        logic [SENSOR_W-1:0] sensor_mv;
    } tick_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [PACK_W-1:0]     s_pack_voltage_dv;
    logic                  s_contactor_sense;
    logic                  s_fault_flag;
    logic [SENSOR_W-1:0]   s_sensor_mv;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_main_relay_en;
    logic                  m_precharge_relay_en;
    logic                  m_fault_latched;
    logic [PHASE_W-1:0]    m_phase;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    precharge_contactor_sequencer dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_pack_voltage_dv    (s_pack_voltage_dv),
        .s_contactor_sense    (s_contactor_sense),
        .s_fault_flag         (s_fault_flag),
        .s_sensor_mv          (s_sensor_mv),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_main_relay_en      (m_main_relay_en),
        .m_precharge_relay_en (m_precharge_relay_en),
        .m_fault_latched      (m_fault_latched),
        .m_phase              (m_phase),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data)
    );

    // sequencer state as the testbench sees it
    cfg_t                seq_cfg;
    phase_t              seq_phase;
    logic [THRESH_W-1:0] seq_threshold;
    logic [TICK_W-1:0]   seq_below;
    logic [TICK_W-1:0]   seq_delay;

    result_t relay_expected[$];
    int      mismatches;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      hold_request;
    int      hold_left;
    int      stalled_cycles;
    int      below_run_left;

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // next relay state for one tick, updating the tracked state
    function automatic result_t advance_sequencer(input tick_t t);
        logic                tripped;
        logic [TICK_W-1:0]   need;
        logic [PROD_W-1:0]   prod;
        result_t             r;
        tripped = t.fault || !t.sense;
        need    = (seq_cfg.qualify_ticks == '0) ? TICK_W'(1) : seq_cfg.qualify_ticks;
        prod    = {{GAIN_W{1'b0}}, t.pack_dv} * {{PACK_W{1'b0}}, seq_cfg.threshold_gain};
        case (seq_phase)
            PH_WAIT: begin
                if (t.pack_dv != '0 && t.sense) begin
                    seq_threshold = THRESH_W'(seq_cfg.threshold_offset_mv)
                                  + THRESH_W'(prod[PROD_W-1:16]);
                    seq_below = '0;
                    seq_phase = PH_QUAL;
                end
            end
            PH_QUAL: begin
                if (tripped) begin
                    seq_phase = PH_FAULT;
                end else begin
                    if (THRESH_W'(t.sensor_mv) < seq_threshold) begin
                        if (seq_below != TICK_MAX) seq_below = seq_below + 1'b1;
                    end else begin
                        seq_below = '0;
                    end
                    if (seq_below >= need) begin
                        seq_delay = '0;
                        if (seq_cfg.close_delay_ticks == '0) seq_phase = PH_DONE;
                        else seq_phase = PH_DELAY;
                    end
                end
            end
            PH_DELAY: begin
                if (seq_delay != TICK_MAX) seq_delay = seq_delay + 1'b1;
                if (seq_delay >= seq_cfg.close_delay_ticks) seq_phase = PH_DONE;
            end
            PH_DONE: begin
                if (tripped) seq_phase = PH_FAULT;
            end
            default: begin
                seq_phase = PH_FAULT;
            end
        endcase
        r.main_relay_en      = (seq_phase == PH_DELAY) || (seq_phase == PH_DONE);
        r.precharge_relay_en = (seq_phase == PH_WAIT) || (seq_phase == PH_QUAL)
                            || (seq_phase == PH_DELAY);
        r.fault_latched      = (seq_phase == PH_FAULT);
        r.phase              = seq_phase;
        return r;
    endfunction

    function automatic tick_t make_tick(input int pack, input bit sense, input bit fault,
                                        input int sensor);
        tick_t t;
        t.pack_dv   = PACK_W'(pack);
        t.sense     = sense;
        t.fault     = fault;
        t.sensor_mv = SENSOR_W'(sensor);
        return t;
    endfunction

    function automatic tick_t random_tick();
        return make_tick($urandom_range(PACK_MAX), $urandom_range(1), $urandom_range(1),
                         $urandom_range(SENSOR_MAX));
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // one tick transaction, with random idle cycles in front of it
    task automatic send_tick(input tick_t t);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid           <= 1'b1;
        s_pack_voltage_dv <= t.pack_dv;
        s_contactor_sense <= t.sense;
        s_fault_flag      <= t.fault;
        s_sensor_mv       <= t.sensor_mv;
        do @(posedge aclk); while (!s_ready);
        relay_expected.push_back(advance_sequencer(t));
    endtask

    // stop offering ticks and wait for every outstanding result
    task automatic wait_for_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (relay_expected.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_THRESHOLD_GAIN:      seq_cfg.threshold_gain      = GAIN_W'(value);
            REG_THRESHOLD_OFFSET_MV: seq_cfg.threshold_offset_mv = OFFSET_W'(value);
            REG_QUALIFY_TICKS:       seq_cfg.qualify_ticks       = TICK_W'(value);
            REG_CLOSE_DELAY_TICKS:   seq_cfg.close_delay_ticks   = TICK_W'(value);
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // healthy tick for qualification: runs below threshold broken by one at or above
    task automatic send_qualifying_tick();
        int sensor;
        if (below_run_left == 0) begin
            sensor         = $urandom_range(SENSOR_MAX, int'(seq_threshold));
            below_run_left = $urandom_range(60, 1);
        end else begin
            sensor         = $urandom_range(int'(seq_threshold) - 1, 0);
            below_run_left--;
        end
        send_tick(make_tick($urandom_range(PACK_MAX), 1'b1, 1'b0, sensor));
    endtask

    // field extremes while waiting, none of which arms the sequence
    task automatic test_waiting_extremes();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_tick(make_tick(0, 1'b1, 1'b0, 0));
        send_tick(make_tick(0, 1'b1, 1'b1, SENSOR_MAX));
        send_tick(make_tick(PACK_MAX, 1'b0, 1'b1, 0));
        send_tick(make_tick(PACK_MAX, 1'b0, 1'b0, SENSOR_MAX));
        send_tick(make_tick(1, 1'b0, 1'b1, 3300));
        send_tick(make_tick(0, 1'b0, 1'b0, 0));
        wait_for_results();
    endtask

    // masked, out-of-range and unused register writes while waiting
    task automatic test_register_codes();
        write_reg(REG_THRESHOLD_GAIN, 0);
        write_reg(REG_THRESHOLD_GAIN, 65535);
        write_reg(REG_THRESHOLD_OFFSET_MV, 16'hFFFF);
        write_reg(REG_QUALIFY_TICKS, 16'hFFFF);
        write_reg(REG_CLOSE_DELAY_TICKS, 16'hFFFF);
        write_reg(REG_SPARE_FIRST, 16'h1234);
        write_reg(REG_SPARE_LAST, 16'hFFFF);
        send_tick(make_tick(0, 1'b1, 1'b1, SENSOR_MAX));
        send_tick(make_tick(PACK_MAX, 1'b0, 1'b0, 0));
        wait_for_results();
    endtask

    // random waiting ticks with the pack unknown or the sense low
    task automatic test_waiting_noise();
        tick_t t;
        send_idle_pct  = 53;
        recv_stall_pct = 0;
        repeat (300) begin
            t = random_tick();
            if ($urandom_range(2) == 0) t.pack_dv = '0;
            else t.sense = 1'b0;
            send_tick(t);
        end
        wait_for_results();
    endtask

    // latch a threshold in a useful window, then probe its edge
    task automatic test_arming();
        int unsigned gain, offset, pack, thr;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        do begin
            gain   = $urandom_range(65535);
            offset = $urandom_range(3300);
            pack   = $urandom_range(PACK_MAX, 1);
            thr    = offset + ((pack * gain) >> 16);
        end while (thr < 600 || thr > 3500);
        write_reg(REG_THRESHOLD_GAIN, gain);
        write_reg(REG_THRESHOLD_OFFSET_MV, offset);
        write_reg(REG_QUALIFY_TICKS, 255);
        write_reg(REG_CLOSE_DELAY_TICKS, 255);
        send_tick(make_tick(pack, 1'b1, 1'b1, $urandom_range(SENSOR_MAX)));
        send_tick(make_tick(0, 1'b1, 1'b0, thr - 1));
        send_tick(make_tick(PACK_MAX, 1'b1, 1'b0, thr));
        send_tick(make_tick(0, 1'b1, 1'b0, SENSOR_MAX));
        send_tick(make_tick(PACK_MAX, 1'b1, 1'b0, 0));
        wait_for_results();
    endtask

    // long qualification without completing, with a receiver hold-off in the middle
    task automatic test_qualification();
        send_idle_pct  = 0;
        recv_stall_pct = 53;
        below_run_left = 0;
        repeat (360) send_qualifying_tick();
        wait_for_results();
        // mid-sequence writes must leave the latched threshold alone
        write_reg(REG_QUALIFY_TICKS, 200);
        write_reg(REG_THRESHOLD_GAIN, 0);
        write_reg(REG_THRESHOLD_OFFSET_MV, 3300);
        hold_request = LONG_HOLD;
        repeat (40) send_qualifying_tick();
        repeat (340) send_qualifying_tick();
        wait_for_results();
    endtask

    // zero qualify count finishes on one low tick, then the delay ignores faults
    task automatic test_closing_delay();
        send_idle_pct  = 10;
        recv_stall_pct = 10;
        write_reg(REG_QUALIFY_TICKS, 0);
        send_tick(make_tick($urandom_range(PACK_MAX), 1'b1, 1'b0,
                            $urandom_range(int'(seq_threshold) - 1, 0)));
        repeat (150) send_tick(random_tick());
        wait_for_results();
        write_reg(REG_CLOSE_DELAY_TICKS, 0);
        repeat (5) send_tick(make_tick($urandom_range(PACK_MAX), 1'b1, 1'b0,
                                       $urandom_range(SENSOR_MAX)));
        wait_for_results();
    endtask

    // healthy ticks keep the sequence done
    task automatic test_done_hold();
        send_idle_pct  = 53;
        recv_stall_pct = 0;
        repeat (300) send_tick(make_tick($urandom_range(PACK_MAX), 1'b1, 1'b0,
                                         $urandom_range(SENSOR_MAX)));
        wait_for_results();
    endtask

    // a fault after completion latches and holds through any input
    task automatic test_fault_latch();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_tick(make_tick($urandom_range(PACK_MAX), 1'b1, 1'b1, $urandom_range(SENSOR_MAX)));
        repeat (100) send_tick(random_tick());
        send_idle_pct  = 10;
        recv_stall_pct = 10;
        repeat (100) send_tick(random_tick());
        wait_for_results();
    endtask

    // receiver ready, with random stalls and a counted hold-off on request
    always @(negedge aclk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (relay_expected.size() == 0) begin
                report_mismatch("result with nothing expected, phase", m_phase, -1);
            end else begin
                want = relay_expected.pop_front();
                if (m_main_relay_en !== want.main_relay_en)
                    report_mismatch("main_relay_en", m_main_relay_en, want.main_relay_en);
                if (m_precharge_relay_en !== want.precharge_relay_en)
                    report_mismatch("precharge_relay_en", m_precharge_relay_en,
                                    want.precharge_relay_en);
                if (m_fault_latched !== want.fault_latched)
                    report_mismatch("fault_latched", m_fault_latched, want.fault_latched);
                if (m_phase !== want.phase)
                    report_mismatch("phase", m_phase, want.phase);
            end
        end
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stalled_cycles <= 0;
        end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("precharge_contactor_sequencer regression: fail");
            $finish;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    initial begin
        aclk              = 1'b0;
        aresetn           = 1'b0;
        s_valid           = 1'b0;
        s_pack_voltage_dv = '0;
        s_contactor_sense = 1'b0;
        s_fault_flag      = 1'b0;
        s_sensor_mv       = '0;
        m_ready           = 1'b0;
        cfg_valid         = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        mismatches        = 0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        hold_request      = 0;
        hold_left         = 0;
        stalled_cycles    = 0;
        below_run_left    = 0;
        seq_cfg           = '{GAIN_RESET, OFFSET_RESET, QUALIFY_RESET, CLOSE_DELAY_RESET};
        seq_phase         = PH_WAIT;
        seq_threshold     = '0;
        seq_below         = '0;
        seq_delay         = '0;

        // reset
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_waiting_extremes();
        test_register_codes();
        test_waiting_noise();
        test_arming();
        test_qualification();
        test_closing_delay();
        test_done_hold();
        test_fault_latch();

        wait_for_results();
        repeat (4) @(posedge aclk);
        if (relay_expected.size() != 0)
            report_mismatch("results still expected", 0, relay_expected.size());
        if (mismatches == 0) begin
            $display("precharge_contactor_sequencer regression: pass");
        end else begin
            $display("precharge_contactor_sequencer regression: fail");
        end
        $finish;
    end

endmodule
